[rtl/core/svap_pkg.sv]
// ----------------------------------------------------------------------------
// svap_pkg
// Types, constants and tables shared by the sampler voice modules.
// ----------------------------------------------------------------------------
package svap_pkg;

  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int FULL_LEVEL       = 32768;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SAMPLE_LENGTH = 3'd0,
    REG_ROOT_NOTE     = 3'd1,
    REG_RATE_RATIO    = 3'd2,
    REG_ATTACK_STEP   = 3'd3,
    REG_DECAY_STEP    = 3'd4,
    REG_RELEASE_STEP  = 3'd5,
    REG_SUSTAIN_LEVEL = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  // one queued command
  typedef struct packed {
    cmd_t               command;
    logic        [15:0] sample_index;
    logic signed [15:0] sample_value;
    logic        [6:0]  note;
    logic        [15:0] velocity;
    logic signed [23:0] mix_in;
  } item_t;

  function automatic logic [16:0] semitone_rom(input logic [3:0] s);
    logic [16:0] r;
    begin
      unique case (s)
        4'd0:    r = 17'd65536;
        4'd1:    r = 17'd69433;
        4'd2:    r = 17'd73562;
        4'd3:    r = 17'd77936;
        4'd4:    r = 17'd82570;
        4'd5:    r = 17'd87480;
        4'd6:    r = 17'd92682;
        4'd7:    r = 17'd98193;
        4'd8:    r = 17'd104032;
        4'd9:    r = 17'd110218;
        4'd10:   r = 17'd116772;
        4'd11:   r = 17'd123715;
        default: r = 17'd65536;
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/core/svap_ram.sv]
// ----------------------------------------------------------------------------
// svap_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module svap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/svap_front.sv]
// ----------------------------------------------------------------------------
// svap_front
// Input stage and two-entry queue between the stream input and the engine.
// ----------------------------------------------------------------------------
module svap_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  svap_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output svap_pkg::item_t q_item
);
  import svap_pkg::*;

  item_t      slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready)
    else $error("queue accepts while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && !$past(push)) |-> !q_valid)
    else $error("queue shows word while empty");
endmodule

[rtl/core/svap_engine.sv]
// ----------------------------------------------------------------------------
// svap_engine
// Voice engine: runs one queued command at a time through a short sequencer.
// ----------------------------------------------------------------------------
module svap_engine #(
  parameter int SAMPLE_DEPTH = svap_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  svap_pkg::item_t     q_item,
  input  logic [16:0]         sample_length,
  input  logic [6:0]          root_note,
  input  logic [31:0]         rate_ratio,
  input  logic [15:0]         attack_step,
  input  logic [15:0]         decay_step,
  input  logic [15:0]         release_step,
  input  logic [15:0]         sustain_level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  mix_out,
  output logic                active
);
  import svap_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(SAMPLE_DEPTH);

  typedef enum logic [2:0] {
    S_WAIT, S_STEP, S_RD0, S_RD1, S_INTERP, S_MUL1, S_MUL2, S_OUT
  } fsm_t;

  fsm_t               fsm;
  item_t              cur;
  stage_t             stage;
  logic [15:0]        env_level;
  logic [32:0]        play_position;
  logic [31:0]        play_step;
  logic [15:0]        note_velocity;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_rdata;
  logic signed [15:0] s0;
  logic signed [16:0] sv;
  logic signed [32:0] prod1;
  logic signed [23:0] mix_res;

  // note-on step arithmetic
  logic signed [7:0]  d;
  logic signed [4:0]  oct;
  logic [3:0]         semi;
  logic [48:0]        p;
  logic [48:0]        ps;
  logic [4:0]         shamt;

  // tick went through the multiply path
  logic               prod2_ok;

  svap_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(cur.sample_value),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [16:0] len;
  logic [16:0] ip;
  logic [15:0] sus;
  assign len = (sample_length > DEPTH17) ? DEPTH17 : sample_length;
  assign ip  = play_position[32:16];
  assign sus = (sustain_level > 16'(FULL_LEVEL)) ? 16'(FULL_LEVEL) : sustain_level;

  assign ram_we    = (fsm == S_STEP) && (cur.command == CMD_LOAD)
                     && ({1'b0, cur.sample_index} < DEPTH17);
  assign ram_waddr = cur.sample_index[AW-1:0];
  // the read issued in S_STEP returns s0 in S_RD0; hold ip + 1 so s1 arrives in S_INTERP
  assign ram_raddr = (fsm == S_RD0 || fsm == S_RD1) ? AW'(ip + 17'd1) : ip[AW-1:0];

  // floor division of d by 12 over -127..127 via compare chain on narrow value
  always_comb begin
    d = $signed({1'b0, cur.note}) - $signed({1'b0, root_note});
    oct = -5'sd11;
    for (int k = -10; k <= 10; k++) begin
      if (d >= 8'(k * 12)) oct = 5'(k);
    end
    semi  = 4'(d - 8'(oct) * 8'sd12);
    shamt = 5'(16 - oct);
  end

  logic signed [46:0] prod2;
  logic signed [46:0] contrib;
  logic signed [25:0] acc;
  assign contrib = prod2 >>> 30;
  assign acc     = 26'(cur.mix_in) + 26'(contrib);

  logic signed [16:0] diff;
  logic signed [33:0] dfrac;
  assign diff  = $signed({ram_rdata[15], ram_rdata}) - $signed({s0[15], s0});
  assign dfrac = 34'(diff) * 34'($signed({1'b0, play_position[15:0]}));

  // envelope advance for one sounding tick
  logic [16:0] env_next;
  stage_t      stage_next;
  always_comb begin
    env_next   = {1'b0, env_level};
    stage_next = stage;
    unique case (stage)
      ST_ATTACK: begin
        env_next = {1'b0, env_level} + {1'b0, attack_step};
        if (env_next >= 17'(FULL_LEVEL)) begin
          env_next   = 17'(FULL_LEVEL);
          stage_next = ST_DECAY;
        end
      end
      ST_DECAY: begin
        if ($signed({2'b0, env_level}) - $signed({2'b0, decay_step})
            <= $signed({2'b0, sus})) begin
          env_next   = {1'b0, sus};
          stage_next = ST_SUSTAIN;
        end else env_next = {1'b0, env_level} - {1'b0, decay_step};
      end
      ST_RELEASE: begin
        if ({1'b0, env_level} <= {1'b0, release_step}) begin
          env_next   = '0;
          stage_next = ST_IDLE;
        end else env_next = {1'b0, env_level} - {1'b0, release_step};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= S_WAIT;
      stage         <= ST_IDLE;
      env_level     <= '0;
      play_position <= '0;
      play_step     <= '0;
      note_velocity <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fsm == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (fsm)
        S_WAIT: begin
          if (q_valid) begin
            cur <= q_item;
            fsm <= S_STEP;
          end
        end
        S_STEP: begin
          mix_res <= cur.mix_in;
          unique case (cur.command)
            CMD_LOAD: fsm <= S_OUT;
            CMD_NOTE_ON: begin
              p   <= 49'(semitone_rom(semi)) * 49'(rate_ratio);
              fsm <= S_MUL1;
            end
            CMD_RELEASE: begin
              if (stage != ST_IDLE) stage <= ST_RELEASE;
              fsm <= S_OUT;
            end
            CMD_TICK: begin
              if (stage == ST_IDLE) begin
                fsm <= S_OUT;
              end else if (len == 17'd0 || ip >= len - 17'd1) begin
                stage <= ST_IDLE;
                fsm   <= S_OUT;
              end else begin
                fsm <= S_RD0;
              end
            end
            default: fsm <= S_OUT;
          endcase
        end
        S_RD0: begin
          s0  <= ram_rdata;
          fsm <= S_RD1;
        end
        S_RD1: fsm <= S_INTERP;
        S_INTERP: begin
          sv        <= $signed({s0[15], s0}) + 17'(dfrac >>> 16);
          env_level <= env_next[15:0];
          stage     <= stage_next;
          fsm       <= S_MUL1;
        end
        S_MUL1: begin
          if (cur.command == CMD_NOTE_ON) begin
            ps <= p >> shamt;
            fsm <= S_MUL2;
          end else begin
            prod1 <= 33'(sv) * 33'($signed({1'b0, env_level}));
            fsm <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (cur.command == CMD_NOTE_ON) begin
            play_step     <= (ps[48:32] != '0) ? 32'hFFFF_FFFF : ps[31:0];
            note_velocity <= (cur.velocity > 16'(FULL_LEVEL)) ? 16'(FULL_LEVEL)
                             : cur.velocity;
            play_position <= '0;
            env_level     <= '0;
            stage         <= ST_ATTACK;
            fsm           <= S_OUT;
          end else begin
            prod2 <= 47'(prod1) * 47'($signed({1'b0, note_velocity}));
            fsm   <= S_OUT;
            play_position <= ({1'b0, play_position} + 34'(play_step) > 34'h1_FFFF_FFFF)
                             ? 33'h1_FFFF_FFFF : play_position + 33'(play_step);
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (cur.command == CMD_TICK && prod2_ok) begin
              mix_out <= (acc > 26'sd8388607) ? 24'sd8388607 :
                         (acc < -26'sd8388608) ? 24'sh80_0000 : acc[23:0];
            end else begin
              mix_out <= mix_res;
            end
            active    <= (stage != ST_IDLE) || (cur.command == CMD_TICK && prod2_ok
                         && stage != ST_IDLE);
            fsm       <= S_WAIT;
          end
        end
        default: fsm <= S_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) prod2_ok <= 1'b0;
    else if (fsm == S_STEP) prod2_ok <= 1'b0;
    else if (fsm == S_MUL2 && cur.command == CMD_TICK) prod2_ok <= 1'b1;
  end

  assign q_pop = (fsm == S_WAIT) && q_valid;

  a_pop_wait: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> fsm == S_STEP)
    else $error("pop without sequencer start");
  a_env_cap: assert property (@(posedge clk) disable iff (rst)
    env_level <= 16'(FULL_LEVEL))
    else $error("envelope above full");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(mix_out))
    else $error("result dropped under stall");
endmodule

[rtl/core/sample_voice_adsr_player_top.sv]
// ----------------------------------------------------------------------------
// sample_voice_adsr_player_top
// Single sampler voice with linear interpolation and ADSR envelope.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tdata carries command, sample_index,
// sample_value, note, velocity and mix_in. Each accepted word gives exactly
// one output word on m_axis with mix_out and the active flag.
// Load, release, idle and ending ticks go from the command step straight to
// output; note on adds the step multiply, shift and update; a sounding tick
// adds two sample store reads, interpolation and two chained multiplies.
// The engine takes one word at a time, the next only after the last has
// passed its output step; a two-entry queue lets the sender keep going
// while the engine works. Registers must be written by the user through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// Reset clears the queue, envelope, position and registers to their defaults;
// the sample store is not cleared. When m_axis_tready is low the result is
// held, the engine waits on it, and s_axis_tready falls once the queue is full.
// ----------------------------------------------------------------------------
module sample_voice_adsr_player_top #(
  parameter int SAMPLE_DEPTH = svap_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0] sample_index[17:2] sample_value[33:18] note[40:34]
  // velocity[56:41] mix_in[80:57]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mix_out[23:0] active[24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import svap_pkg::*;

  logic [16:0] sample_length;
  logic [6:0]  root_note;
  logic [31:0] rate_ratio;
  logic [15:0] attack_step, decay_step, release_step, sustain_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_length <= '0;
      root_note     <= 7'd60;
      rate_ratio    <= 32'd65536;
      attack_step   <= 16'd7;
      decay_step    <= 16'd1;
      release_step  <= 16'd1;
      sustain_level <= 16'd22938;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SAMPLE_LENGTH: sample_length <= cfg_data[16:0];
        REG_ROOT_NOTE:     root_note     <= cfg_data[6:0];
        REG_RATE_RATIO:    rate_ratio    <= cfg_data;
        REG_ATTACK_STEP:   attack_step   <= cfg_data[15:0];
        REG_DECAY_STEP:    decay_step    <= cfg_data[15:0];
        REG_RELEASE_STEP:  release_step  <= cfg_data[15:0];
        REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  item_t in_item, q_item;
  logic  q_valid, q_pop;
  logic signed [23:0] mix_out;
  logic  active;

  assign in_item.command      = cmd_t'(s_axis_tdata[1:0]);
  assign in_item.sample_index = s_axis_tdata[17:2];
  assign in_item.sample_value = s_axis_tdata[33:18];
  assign in_item.note         = s_axis_tdata[40:34];
  assign in_item.velocity     = s_axis_tdata[56:41];
  assign in_item.mix_in       = s_axis_tdata[80:57];

  svap_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  svap_engine #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .sample_length(sample_length), .root_note(root_note), .rate_ratio(rate_ratio),
    .attack_step(attack_step), .decay_step(decay_step),
    .release_step(release_step), .sustain_level(sustain_level),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .mix_out(mix_out), .active(active)
  );

  assign m_axis_tdata = {7'd0, active, mix_out};
endmodule
